/* src/bpsc_pkg.sv */
// ----------------------------------------------------------------------------
// bpsc_pkg: shared types and constants of the pressure support command block
// Field widths, register indexes, reset values and the fixed point helper.
// ----------------------------------------------------------------------------
package bpsc_pkg;

  localparam int EPAP_W     = 12;
  localparam int SUPPORT_W  = 12;
  localparam int RISE_W     = 11;
  localparam int PRE_W      = 8;
  localparam int TIME_W     = 16;
  localparam int VOL_W      = 12;
  localparam int CMD_W      = 13;
  localparam int IPAP_W     = 14;
  localparam int PROG_W     = 16;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 12;

  // Q0.16 fractions are one bit wider so that 1.0 is representable.
  localparam int FRAC_W = 17;
  localparam logic [FRAC_W-1:0] FRAC_ONE = 17'h10000;

  // Divider lanes: rise fraction (den = 2 * rise time) and volume gate
  // (den = 6 * peak volume).
  localparam int RISE_DEN_W = 12;
  localparam int VOL_DEN_W  = 15;
  localparam int QUO_W      = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_EPAP    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SUPPORT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_RISE    = 2'd2;

  localparam logic [EPAP_W-1:0]    EPAP_RESET    = 12'd400;
  localparam logic [SUPPORT_W-1:0] SUPPORT_RESET = 12'd400;
  localparam logic [RISE_W-1:0]    RISE_RESET    = 11'd300;

  // Side data that rides along the divider stages.
  typedef struct packed {
    logic                     inh;
    logic [PRE_W-1:0]         pre;
    logic [PROG_W-1:0]        prog;
    logic                     rise_full;
    logic                     rise_zero;
    logic signed [CMD_W-1:0]  fps;
    logic [FRAC_W-1:0]        m;
    logic [FRAC_W-1:0]        e2;
    logic                     vol_off;
    logic                     vol_zero;
    logic                     vol_full;
  } side_t;

  // floor(x * 65536 / 800) for x in 1..799, as x*81 + floor(x*23/25).
  function automatic logic [FRAC_W-1:0] frac800(input logic [9:0] x);
    logic [26:0] t;
    t = 27'(x) * 27'd120589;
    return 17'(x) * 17'd81 + 17'(t[26:17]);
  endfunction

endpackage

/* src/bpsc_sample_if.sv */
// ----------------------------------------------------------------------------
// bpsc_sample_if: input channel of the pressure support command block
// Valid/ready channel that carries one tick of breath phase data.
// ----------------------------------------------------------------------------
interface bpsc_sample_if import bpsc_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic                    inhaling;
  logic [PRE_W-1:0]        pre_cycle_count;
  logic [TIME_W-1:0]       inhale_time_ms;
  logic [TIME_W-1:0]       exhale_time_ms;
  logic [VOL_W-1:0]        volume_ml;
  logic [VOL_W-1:0]        peak_volume_ml;
  logic signed [CMD_W-1:0] last_support;
  logic [PROG_W-1:0]       progress_q16;

  modport source(output valid, inhaling, pre_cycle_count, inhale_time_ms, exhale_time_ms,
                 volume_ml, peak_volume_ml, last_support, progress_q16, input ready);
  modport sink(input valid, inhaling, pre_cycle_count, inhale_time_ms, exhale_time_ms,
               volume_ml, peak_volume_ml, last_support, progress_q16, output ready);
endinterface

/* src/bpsc_command_if.sv */
// ----------------------------------------------------------------------------
// bpsc_command_if: output channel of the pressure support command block
// Valid/ready channel that carries one pressure command.
// ----------------------------------------------------------------------------
interface bpsc_command_if import bpsc_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic signed [CMD_W-1:0]  support_cmd;
  logic [EPAP_W-1:0]        epap_cmd;
  logic signed [IPAP_W-1:0] ipap_cmd;

  modport source(output valid, support_cmd, epap_cmd, ipap_cmd, input ready);
  modport sink(input valid, support_cmd, epap_cmd, ipap_cmd, output ready);
endinterface

/* src/bpsc_div.sv */
// ----------------------------------------------------------------------------
// bpsc_div: pipelined restoring divider
// One quotient bit per stage; numerator is below the divisor on entry.
// ----------------------------------------------------------------------------
module bpsc_div #(
  parameter int DW = 12,
  parameter int QW = 16
) (
  input  logic          clk,
  input  logic          en,
  input  logic [DW-1:0] num,
  input  logic [DW-1:0] den,
  output logic [QW-1:0] quo
);

  logic [DW-1:0] rem_q [QW];
  logic [DW-1:0] den_q [QW];
  logic [QW-1:0] quo_q [QW];

  for (genvar j = 0; j < QW; j++) begin : g_stage
    logic [DW-1:0] r_in;
    logic [DW-1:0] d_in;
    logic [QW-1:0] q_in;
    logic [DW:0]   sh;
    logic [DW:0]   df;

    if (j == 0) begin : g_first
      assign r_in = num;
      assign d_in = den;
      assign q_in = '0;
    end else begin : g_next
      assign r_in = rem_q[j-1];
      assign d_in = den_q[j-1];
      assign q_in = quo_q[j-1];
    end

    assign sh = {r_in, 1'b0};
    assign df = sh - {1'b0, d_in};

    always_ff @(posedge clk) begin
      if (en) begin
        den_q[j] <= d_in;
        if (sh >= {1'b0, d_in}) begin
          rem_q[j] <= df[DW-1:0];
          quo_q[j] <= {q_in[QW-2:0], 1'b1};
        end else begin
          rem_q[j] <= sh[DW-1:0];
          quo_q[j] <= {q_in[QW-2:0], 1'b0};
        end
      end
    end
  end

  assign quo = quo_q[QW-1];

endmodule

/* src/breath_pressure_support_command_core.sv */
// ----------------------------------------------------------------------------
// breath_pressure_support_command_core: pressure support command pipeline
// Turns one tick of breath phase data into support, EPAP and IPAP commands.
// ----------------------------------------------------------------------------
// Usage:
//   Each transaction on the sample channel carries the breath phase data of
//   one control tick; it yields exactly one transaction on the command
//   channel, in order. Registers are written through the plain write port
//   (cfg_wr_en, cfg_index, cfg_data) while no transaction is in flight.
// Throughput and depth:
//   One sample is taken every cycle while the command channel does not stall.
//   The depth is set by the two 16-stage restoring dividers (rise fraction
//   and volume gate), one quotient bit a stage, framed by one input stage and
//   six stages of multiplies, rounding and clamping.
// Stalls and reset:
//   The whole pipeline advances together; when the command channel holds a
//   result that is not taken, every stage holds and sample.ready drops, so
//   nothing is lost or repeated. Reset empties the pipeline (all valid bits
//   clear) and loads the register defaults: EPAP 400, support 400, rise
//   time 300 ms.
// ----------------------------------------------------------------------------
module breath_pressure_support_command_core
  import bpsc_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  bpsc_sample_if.sink           sample,
  bpsc_command_if.source        command
);

  localparam int NSTAGE = 1 + QUO_W + 6;

  // Configuration registers.
  logic [EPAP_W-1:0]    epap_level;
  logic [SUPPORT_W-1:0] support_pressure;
  logic [RISE_W-1:0]    rise_time_ms;

  always_ff @(posedge clk) begin
    if (rst) begin
      epap_level       <= EPAP_RESET;
      support_pressure <= SUPPORT_RESET;
      rise_time_ms     <= RISE_RESET;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        CFG_EPAP:    epap_level       <= cfg_data[EPAP_W-1:0];
        CFG_SUPPORT: support_pressure <= cfg_data[SUPPORT_W-1:0];
        CFG_RISE:    rise_time_ms     <= cfg_data[RISE_W-1:0];
        default: ;
      endcase
    end
  end

  // The pipeline moves as one; valid bits travel with the data.
  logic              en;
  logic [NSTAGE-1:0] vld;

  assign en           = !vld[NSTAGE-1] || command.ready;
  assign sample.ready = en;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[NSTAGE-2:0], sample.valid};
    end
  end

  // ---- Stage 1: rise numerator, volume gate numerator, time fractions ----
  // k is the start of the smoothing knee; the last 75 ms of the rise count
  // at half speed, so the numerator is 2*min(t,k) + clamp(t-k, 0, 150).
  logic signed [12:0]    knee;
  logic signed [17:0]    tk;
  logic signed [12:0]    t_min;
  logic [7:0]            t_knee;
  logic signed [13:0]    rise_num;
  logic [RISE_DEN_W-1:0] rise_den;
  logic                  rise_zero;
  logic                  rise_full;
  logic [15:0]           vol10;
  logic signed [16:0]    vol_num;
  logic [VOL_DEN_W-1:0]  vol_den;
  logic                  vol_off;
  logic                  vol_zero;
  logic                  vol_full;
  logic [FRAC_W-1:0]     m_frac;
  logic [FRAC_W-1:0]     e2_frac;
  side_t                 side_in;

  always_comb begin
    knee     = $signed({2'b00, rise_time_ms}) - 13'sd75;
    tk       = $signed({2'b00, sample.inhale_time_ms}) - 18'(knee);
    t_min    = tk[17] ? $signed({2'b00, sample.inhale_time_ms[10:0]}) : knee;
    if (tk <= 18'sd0) begin
      t_knee = 8'd0;
    end else if (tk > 18'sd150) begin
      t_knee = 8'd150;
    end else begin
      t_knee = tk[7:0];
    end
    rise_num  = $signed({t_min, 1'b0}) + $signed({6'b0, t_knee});
    rise_den  = {rise_time_ms, 1'b0};
    rise_zero = (rise_num <= 14'sd0);
    rise_full = (rise_time_ms == '0) || (rise_num >= $signed({2'b00, rise_den}));

    // Volume gate: (10*vol - peak) / (6*peak); a zero peak switches it off.
    vol10    = 16'(sample.volume_ml) * 16'd10;
    vol_num  = $signed({1'b0, vol10}) - $signed({5'b0, sample.peak_volume_ml});
    vol_den  = 15'(sample.peak_volume_ml) * 15'd6;
    vol_off  = (sample.peak_volume_ml == '0);
    vol_zero = (vol_num <= 17'sd0);
    vol_full = (vol_num >= $signed({2'b00, vol_den}));

    // Decay fraction over 800 ms and the time gate from 400 to 1200 ms.
    if (sample.exhale_time_ms >= 16'd800) begin
      m_frac = '0;
    end else if (sample.exhale_time_ms == '0) begin
      m_frac = FRAC_ONE;
    end else begin
      m_frac = frac800(10'(16'd800 - sample.exhale_time_ms));
    end
    if (sample.exhale_time_ms >= 16'd1200) begin
      e2_frac = '0;
    end else if (sample.exhale_time_ms <= 16'd400) begin
      e2_frac = FRAC_ONE;
    end else begin
      e2_frac = frac800(10'(16'd1200 - sample.exhale_time_ms));
    end

    side_in.inh       = sample.inhaling;
    side_in.pre       = sample.pre_cycle_count;
    side_in.prog      = sample.progress_q16;
    side_in.rise_full = rise_full;
    side_in.rise_zero = rise_zero;
    side_in.fps       = sample.last_support;
    side_in.m         = m_frac;
    side_in.e2        = e2_frac;
    side_in.vol_off   = vol_off;
    side_in.vol_zero  = vol_zero;
    side_in.vol_full  = vol_full;
  end

  side_t                 s1_side;
  logic [RISE_DEN_W-1:0] s1_rise_rem;
  logic [RISE_DEN_W-1:0] s1_rise_den;
  logic [VOL_DEN_W-1:0]  s1_vol_rem;
  logic [VOL_DEN_W-1:0]  s1_vol_den;

  // Out-of-range numerators are settled by the flags; the divider then
  // sees a zero numerator.
  always_ff @(posedge clk) begin
    if (en) begin
      s1_side     <= side_in;
      s1_rise_rem <= (rise_zero || rise_full) ? '0 : rise_num[RISE_DEN_W-1:0];
      s1_rise_den <= rise_den;
      s1_vol_rem  <= (vol_off || vol_zero || vol_full) ? '0 : vol_num[VOL_DEN_W-1:0];
      s1_vol_den  <= vol_den;
    end
  end

  // ---- Divider stages ----
  logic [QUO_W-1:0] rise_quo;
  logic [QUO_W-1:0] vol_quo;
  side_t            side_line [QUO_W];

  bpsc_div #(.DW(RISE_DEN_W), .QW(QUO_W)) u_rise_div (
    .clk (clk),
    .en  (en),
    .num (s1_rise_rem),
    .den (s1_rise_den),
    .quo (rise_quo)
  );

  bpsc_div #(.DW(VOL_DEN_W), .QW(QUO_W)) u_vol_div (
    .clk (clk),
    .en  (en),
    .num (s1_vol_rem),
    .den (s1_vol_den),
    .quo (vol_quo)
  );

  always_ff @(posedge clk) begin
    if (en) begin
      side_line[0] <= s1_side;
      for (int j = 1; j < QUO_W; j++) begin
        side_line[j] <= side_line[j-1];
      end
    end
  end

  // ---- P1: resolve fractions, inspiratory sum, square of the decay ----
  side_t              ds;
  logic [FRAC_W-1:0]  rise_frac;
  logic [FRAC_W-1:0]  e1_frac;
  logic [FRAC_W-1:0]  eps;
  logic signed [28:0] p_sum;

  always_comb begin
    ds = side_line[QUO_W-1];
    if (ds.rise_full) begin
      rise_frac = FRAC_ONE;
    end else if (ds.rise_zero) begin
      rise_frac = '0;
    end else begin
      rise_frac = {1'b0, rise_quo};
    end
    if (ds.vol_full) begin
      e1_frac = FRAC_ONE;
    end else if (ds.vol_zero) begin
      e1_frac = '0;
    end else begin
      e1_frac = {1'b0, vol_quo};
    end
    if (ds.vol_off) begin
      eps = '0;
    end else begin
      eps = (e1_frac < ds.e2) ? e1_frac : ds.e2;
    end
    // 0.1 + 0.7*rise + 0.4*progress - pre/150, scaled by 1500 * 65536.
    p_sum = 29'sd9830400
          + $signed({1'b0, 28'(rise_frac) * 28'd1050})
          + $signed({1'b0, 28'(ds.prog) * 28'd600})
          - $signed({1'b0, 28'(ds.pre) * 28'd655360});
  end

  logic                    p1_inh;
  logic [26:0]             p1_p;
  logic [33:0]             p1_sq;
  logic [FRAC_W-1:0]       p1_eps;
  logic signed [CMD_W-1:0] p1_fps;

  always_ff @(posedge clk) begin
    if (en) begin
      p1_inh <= ds.inh;
      p1_p   <= p_sum[28] ? '0 : p_sum[26:0];
      p1_sq  <= 34'(ds.m) * 34'(ds.m);
      p1_eps <= eps;
      p1_fps <= ds.fps;
    end
  end

  // ---- P2: support times fraction; squared decay times 19 over 2^18 ----
  logic                    p2_inh;
  logic [38:0]             p2_prod;
  logic [18:0]             p2_w;
  logic [FRAC_W-1:0]       p2_eps;
  logic signed [CMD_W-1:0] p2_fps;
  logic [37:0]             sq19;

  assign sq19 = 38'(p1_sq) * 38'd19;

  always_ff @(posedge clk) begin
    if (en) begin
      p2_inh  <= p1_inh;
      p2_prod <= 39'(p1_p) * 39'(support_pressure);
      p2_w    <= sq19[36:18];
      p2_eps  <= p1_eps;
      p2_fps  <= p1_fps;
    end
  end

  // ---- P3: round and shift the inspiratory product; decay over 5 ----
  logic                    p3_inh;
  logic [20:0]             p3_v;
  logic [15:0]             p3_d;
  logic [FRAC_W-1:0]       p3_eps;
  logic signed [CMD_W-1:0] p3_fps;
  logic [39:0]             prod_rnd;
  logic [37:0]             w_div5;

  assign prod_rnd = 40'(p2_prod) + 40'd49152000;
  assign w_div5   = 38'(p2_w) * 38'd419431;

  always_ff @(posedge clk) begin
    if (en) begin
      p3_inh <= p2_inh;
      p3_v   <= prod_rnd[38:18];
      p3_d   <= w_div5[36:21];
      p3_eps <= p2_eps;
      p3_fps <= p2_fps;
    end
  end

  // ---- P4: divide by 375; decayed support and offset share ----
  logic               p4_inh;
  logic [12:0]        p4_q;
  logic signed [29:0] p4_a;
  logic [33:0]        p4_b;
  logic [41:0]        v_div;
  logic [FRAC_W-1:0]  d_rest;

  assign v_div  = 42'(p3_v) * 42'd1431656;
  assign d_rest = FRAC_ONE - {1'b0, p3_d};

  always_ff @(posedge clk) begin
    if (en) begin
      p4_inh <= p3_inh;
      p4_q   <= v_div[41:29];
      p4_a   <= $signed({1'b0, p3_d}) * p3_fps;
      p4_b   <= 34'(d_rest) * 34'(p3_eps);
    end
  end

  // ---- P5: expiratory blend, rounded half up over 2^32 ----
  logic signed [47:0] exh_num;
  logic signed [15:0] p5_cmd;

  assign exh_num = (48'(p4_a) <<< 16) - $signed(48'(p4_b) * 48'd80) + 48'sd2147483648;

  always_ff @(posedge clk) begin
    if (en) begin
      p5_cmd <= p4_inh ? $signed({3'b000, p4_q}) : exh_num[47:32];
    end
  end

  // ---- P6: clamp to [-80, support], add EPAP, output register ----
  logic signed [CMD_W-1:0] cmd_clamped;

  always_comb begin
    if (p5_cmd < -16'sd80) begin
      cmd_clamped = -13'sd80;
    end else if (p5_cmd > $signed({4'b0000, support_pressure})) begin
      cmd_clamped = $signed({1'b0, support_pressure});
    end else begin
      cmd_clamped = p5_cmd[CMD_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      command.support_cmd <= cmd_clamped;
      command.epap_cmd    <= epap_level;
      command.ipap_cmd    <= $signed({2'b00, epap_level}) + 14'(cmd_clamped);
    end
  end

  assign command.valid = vld[NSTAGE-1];

endmodule
